// ----- rtl/core/euclidean_distance_and_range_check_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the euclidean distance and range check block.
// Both sample on the rising edge of clk_i; the first is held off during reset.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_DISTANCE_AND_RANGE_CHECK_MACROS_SVH
`define EUCLIDEAN_DISTANCE_AND_RANGE_CHECK_MACROS_SVH

`define EDR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define EDR_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/edr_pkg.sv -----
// ----------------------------------------------------------------------------
// edr_pkg
// Shared constants and command codes of the distance and range check block.
// ----------------------------------------------------------------------------
package edr_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int LIMIT_WIDTH     = 26;
  localparam int LIMIT_MAG_WIDTH = LIMIT_WIDTH - 1;
  localparam int LIMIT_SQ_WIDTH  = 2 * LIMIT_MAG_WIDTH;
  localparam int CMD_WIDTH       = 2;

  localparam logic [CMD_WIDTH-1:0] CMD_DIST3D  = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_RANGE3D = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_DIST2D  = 2'd2;

endpackage

// ----- rtl/core/edr_if.sv -----
// ----------------------------------------------------------------------------
// edr_if
// Request and result channels of the distance and range check block.
// ----------------------------------------------------------------------------
interface edr_in_if #(
  parameter int CoordWidth = edr_pkg::COORD_WIDTH
);
  logic                                 valid;
  logic                                 ready;
  logic        [edr_pkg::CMD_WIDTH-1:0] command;
  logic signed [CoordWidth-1:0]         from_x;
  logic signed [CoordWidth-1:0]         from_y;
  logic signed [CoordWidth-1:0]         from_z;
  logic signed [CoordWidth-1:0]         to_x;
  logic signed [CoordWidth-1:0]         to_y;
  logic signed [CoordWidth-1:0]         to_z;
  logic signed [edr_pkg::LIMIT_WIDTH-1:0] limit;

  modport source (
    output valid, command, from_x, from_y, from_z, to_x, to_y, to_z, limit,
    input  ready
  );
  modport sink (
    input  valid, command, from_x, from_y, from_z, to_x, to_y, to_z, limit,
    output ready
  );
endinterface

interface edr_out_if #(
  parameter int CoordWidth = edr_pkg::COORD_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [CoordWidth:0]   distance;
  logic                  within_range;

  modport source (
    output valid, distance, within_range,
    input  ready
  );
  modport sink (
    input  valid, distance, within_range,
    output ready
  );
endinterface

// ----- rtl/core/euclidean_distance_and_range_check.sv -----
// ----------------------------------------------------------------------------
// euclidean_distance_and_range_check: floor Euclidean distance and range flag.
// Registered stages: differences, squares, sum and range compare, then the
// one-bit-per-stage square root. One request per cycle while not stalled.
// Reset clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module euclidean_distance_and_range_check #(
  parameter int CoordWidth = edr_pkg::COORD_WIDTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  edr_in_if.sink   in_i,
  edr_out_if.source out_o
);

  logic                                diff_valid, diff_ready;
  logic [CoordWidth-1:0]               dx, dy, dz;
  logic [edr_pkg::LIMIT_MAG_WIDTH-1:0] lim_mag;
  logic                                rng_en;

  logic                                sq_valid, sq_ready;
  logic [2*CoordWidth+1:0]             sum;
  logic                                sq_within;

  edr_diff #(
    .CoordWidth(CoordWidth)
  ) u_diff (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .ready_o   (in_i.ready),
    .command_i (in_i.command),
    .from_x_i  (in_i.from_x),
    .from_y_i  (in_i.from_y),
    .from_z_i  (in_i.from_z),
    .to_x_i    (in_i.to_x),
    .to_y_i    (in_i.to_y),
    .to_z_i    (in_i.to_z),
    .limit_i   (in_i.limit),
    .valid_o   (diff_valid),
    .ready_i   (diff_ready),
    .dx_o      (dx),
    .dy_o      (dy),
    .dz_o      (dz),
    .lim_mag_o (lim_mag),
    .rng_en_o  (rng_en)
  );

  edr_square #(
    .CoordWidth(CoordWidth)
  ) u_square (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (diff_valid),
    .ready_o   (diff_ready),
    .dx_i      (dx),
    .dy_i      (dy),
    .dz_i      (dz),
    .lim_mag_i (lim_mag),
    .rng_en_i  (rng_en),
    .valid_o   (sq_valid),
    .ready_i   (sq_ready),
    .sum_o     (sum),
    .within_o  (sq_within)
  );

  edr_sqrt #(
    .CoordWidth(CoordWidth)
  ) u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sq_valid),
    .ready_o  (sq_ready),
    .rem_i    (sum),
    .within_i (sq_within),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .root_o   (out_o.distance),
    .within_o (out_o.within_range)
  );

endmodule

// ----- rtl/core/edr_diff.sv -----
// ----------------------------------------------------------------------------
// edr_diff
// First stage: absolute coordinate differences and limit decode.
// ----------------------------------------------------------------------------
module edr_diff #(
  parameter int CoordWidth = edr_pkg::COORD_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic        [edr_pkg::CMD_WIDTH-1:0]   command_i,
  input  logic signed [CoordWidth-1:0]           from_x_i,
  input  logic signed [CoordWidth-1:0]           from_y_i,
  input  logic signed [CoordWidth-1:0]           from_z_i,
  input  logic signed [CoordWidth-1:0]           to_x_i,
  input  logic signed [CoordWidth-1:0]           to_y_i,
  input  logic signed [CoordWidth-1:0]           to_z_i,
  input  logic signed [edr_pkg::LIMIT_WIDTH-1:0] limit_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic        [CoordWidth-1:0]           dx_o,
  output logic        [CoordWidth-1:0]           dy_o,
  output logic        [CoordWidth-1:0]           dz_o,
  output logic [edr_pkg::LIMIT_MAG_WIDTH-1:0]    lim_mag_o,
  output logic                                   rng_en_o
);

  function automatic logic [CoordWidth-1:0] abs_diff(
    input logic [CoordWidth-1:0] a,
    input logic [CoordWidth-1:0] b
  );
    logic [CoordWidth:0] d;
    logic [CoordWidth:0] m;
    d = {a[CoordWidth-1], a} - {b[CoordWidth-1], b};
    m = d[CoordWidth] ? (~d + 1'b1) : d;
    return m[CoordWidth-1:0];
  endfunction

  logic                               valid_q;
  logic [CoordWidth-1:0]              dx_q, dy_q, dz_q;
  logic [CoordWidth-1:0]              dx_d, dy_d, dz_d;
  logic [edr_pkg::LIMIT_MAG_WIDTH-1:0] lim_mag_q;
  logic                               rng_en_q, rng_en_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    dx_d     = abs_diff(from_x_i, to_x_i);
    dz_d     = abs_diff(from_z_i, to_z_i);
    dy_d     = (command_i == edr_pkg::CMD_DIST2D) ? '0 : abs_diff(from_y_i, to_y_i);
    rng_en_d = (command_i == edr_pkg::CMD_RANGE3D) && !limit_i[edr_pkg::LIMIT_WIDTH-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dx_q      <= dx_d;
      dy_q      <= dy_d;
      dz_q      <= dz_d;
      lim_mag_q <= limit_i[edr_pkg::LIMIT_MAG_WIDTH-1:0];
      rng_en_q  <= rng_en_d;
    end
  end

  assign valid_o   = valid_q;
  assign dx_o      = dx_q;
  assign dy_o      = dy_q;
  assign dz_o      = dz_q;
  assign lim_mag_o = lim_mag_q;
  assign rng_en_o  = rng_en_q;

endmodule

// ----- rtl/core/edr_square.sv -----
// ----------------------------------------------------------------------------
// edr_square
// Three stages: squares, sum of squares, and the range comparison.
// ----------------------------------------------------------------------------
module edr_square #(
  parameter int CoordWidth = edr_pkg::COORD_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [CoordWidth-1:0]               dx_i,
  input  logic [CoordWidth-1:0]               dy_i,
  input  logic [CoordWidth-1:0]               dz_i,
  input  logic [edr_pkg::LIMIT_MAG_WIDTH-1:0] lim_mag_i,
  input  logic                                rng_en_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [2*CoordWidth+1:0]             sum_o,
  output logic                                within_o
);

  localparam int SqWidth  = 2 * CoordWidth;
  localparam int SumWidth = SqWidth + 2;
  localparam int CmpWidth = (SumWidth > edr_pkg::LIMIT_SQ_WIDTH) ? SumWidth :
                                                                   edr_pkg::LIMIT_SQ_WIDTH;
  localparam int LimSqW   = edr_pkg::LIMIT_SQ_WIDTH;

  logic [2:0]              valid_q;
  logic [2:0]              rdy;

  logic [SqWidth-1:0]      sx_q, sy_q, sz_q;
  logic [LimSqW-1:0]       lim_sq_q;
  logic                    rng_en_q;

  logic [SumWidth-1:0]     sum_q;
  logic [LimSqW-1:0]       lim_sq2_q;
  logic                    rng_en2_q;

  logic [SumWidth-1:0]     sum3_q;
  logic                    within_q, within_d;

  assign rdy[2]  = !valid_q[2] || ready_i;
  assign rdy[1]  = !valid_q[1] || rdy[2];
  assign rdy[0]  = !valid_q[0] || rdy[1];
  assign ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= valid_i;
      end
      if (rdy[1]) begin
        valid_q[1] <= valid_q[0];
      end
      if (rdy[2]) begin
        valid_q[2] <= valid_q[1];
      end
    end
  end

  assign within_d = rng_en2_q && (CmpWidth'(sum_q) <= CmpWidth'(lim_sq2_q));

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      sx_q     <= SqWidth'(dx_i) * SqWidth'(dx_i);
      sy_q     <= SqWidth'(dy_i) * SqWidth'(dy_i);
      sz_q     <= SqWidth'(dz_i) * SqWidth'(dz_i);
      lim_sq_q <= LimSqW'(lim_mag_i) * LimSqW'(lim_mag_i);
      rng_en_q <= rng_en_i;
    end
    if (rdy[1] && valid_q[0]) begin
      sum_q     <= SumWidth'(sx_q) + SumWidth'(sy_q) + SumWidth'(sz_q);
      lim_sq2_q <= lim_sq_q;
      rng_en2_q <= rng_en_q;
    end
    if (rdy[2] && valid_q[1]) begin
      sum3_q   <= sum_q;
      within_q <= within_d;
    end
  end

  assign valid_o  = valid_q[2];
  assign sum_o    = sum3_q;
  assign within_o = within_q;

endmodule

// ----- rtl/core/edr_sqrt.sv -----
// ----------------------------------------------------------------------------
// edr_sqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module edr_sqrt #(
  parameter int CoordWidth = edr_pkg::COORD_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [2*CoordWidth+1:0] rem_i,
  input  logic                    within_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [CoordWidth:0]     root_o,
  output logic                    within_o
);

  localparam int RootWidth = CoordWidth + 1;
  localparam int RemWidth  = 2 * CoordWidth + 2;

  logic [RootWidth-1:0] valid_q;
  logic [RootWidth:0]   rdy;
  logic [RemWidth-1:0]  rem_q    [RootWidth-1];
  logic [RootWidth-1:0] root_q   [RootWidth];
  logic                 within_q [RootWidth];

  assign rdy[RootWidth] = ready_i;
  assign ready_o        = rdy[0];

  for (genvar s = 0; s < RootWidth; s++) begin : g_stage
    localparam int Bit = RootWidth - 1 - s;

    logic [RemWidth-1:0]  rem_in;
    logic [RootWidth-1:0] root_in;
    logic                 within_in;
    logic                 valid_in;
    logic [RemWidth-1:0]  trial;
    logic                 take;
    logic [RootWidth-1:0] root_d;

    if (s == 0) begin : g_first
      assign rem_in    = rem_i;
      assign root_in   = '0;
      assign within_in = within_i;
      assign valid_in  = valid_i;
    end else begin : g_next
      assign rem_in    = rem_q[s-1];
      assign root_in   = root_q[s-1];
      assign within_in = within_q[s-1];
      assign valid_in  = valid_q[s-1];
    end

    assign rdy[s]  = !valid_q[s] || rdy[s+1];
    assign trial   = (RemWidth'(root_in) << (Bit + 1)) | (RemWidth'(1) << (2 * Bit));
    assign take    = rem_in >= trial;
    assign root_d  = take ? (root_in | (RootWidth'(1) << Bit)) : root_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && valid_in) begin
        root_q[s]   <= root_d;
        within_q[s] <= within_in;
      end
    end

    if (s < RootWidth - 1) begin : g_rem
      logic [RemWidth-1:0] rem_d;

      assign rem_d = take ? (rem_in - trial) : rem_in;

      always_ff @(posedge clk_i) begin
        if (rdy[s] && valid_in) begin
          rem_q[s] <= rem_d;
        end
      end
    end
  end

  assign valid_o  = valid_q[RootWidth-1];
  assign root_o   = root_q[RootWidth-1];
  assign within_o = within_q[RootWidth-1];

endmodule

// ----- rtl/core/edr_checker.sv -----
// ----------------------------------------------------------------------------
// edr_checker
// Port-level checks of the distance and range check block, bound to its top.
// ----------------------------------------------------------------------------
`include "euclidean_distance_and_range_check_macros.svh"

module edr_checker #(
  parameter int CoordWidth = edr_pkg::COORD_WIDTH
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [CoordWidth:0] distance,
  input logic                within_range
);

  // An empty or draining output stage must let a new request in.
  `EDR_ASSERT(a_ready_when_free, (!out_valid || out_ready) |-> in_ready, "request refused while output free")

  `EDR_ASSERT(a_result_held, (out_valid && !out_ready) |=> (out_valid && $stable(distance) && $stable(within_range)), "stalled result changed")

  `EDR_ASSERT_NR(a_reset_empty, $past(!rst_ni) |-> !out_valid, "result shown right after reset")

  `EDR_ASSERT(a_stall_full, (in_valid && !in_ready) |-> (out_valid && !out_ready), "request refused without output stall")

endmodule

bind euclidean_distance_and_range_check edr_checker #(
  .CoordWidth(CoordWidth)
) u_edr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .distance     (out_o.distance),
  .within_range (out_o.within_range)
);
